// ===== design/txcc_pkg.sv =====
// Package for the transmit coalescing controller: item and result layouts,
// state, status and op codes. No dependencies.
package txcc_pkg;

  localparam int unsigned WindowW = 16;
  localparam logic [WindowW-1:0] WindowReset = 16'd100;
  localparam logic [WindowW-1:0] ElapsedMax  = {WindowW{1'b1}};

  typedef enum logic [2:0] {
    ST_INIT     = 3'd0,
    ST_WAIT     = 3'd1,
    ST_START    = 3'd2,
    ST_DONEWAIT = 3'd3,
    ST_HALT     = 3'd4
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RS_IDLE    = 2'd0,
    RS_PENDING = 2'd1,
    RS_DONE    = 2'd2,
    RS_FAILED  = 2'd3
  } req_status_e;

  typedef enum logic [2:0] {
    OP_RUN     = 3'd0,
    OP_REQUEST = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_DONE    = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  // Source bits of a packet.
  localparam int unsigned SrcSysBit = 0;
  localparam int unsigned SrcReqBit = 1;
  localparam logic [1:0]  SrcSys    = 2'b01;
  localparam logic [1:0]  SrcReq    = 2'b10;
  localparam logic [1:0]  SrcBoth   = SrcSys | SrcReq;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic       radio_ok;
    logic       busy_pin;
    logic       system_ready;
    logic       request_valid;
    logic [2:0] op;
  } item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic        busy_res;
    logic        standby;
    logic        clear_system_ready;
    logic [1:0]  packet_sources;
    logic        start_transmit;
    logic        request_accepted;
    req_status_e tx_status;
    ctrl_state_e fsm_state;
  } result_t;

  localparam int unsigned ItemW   = $bits(item_t);
  localparam int unsigned ResultW = $bits(result_t);

endpackage

// ===== design/txcc_core.sv =====
// Controller state and per-item next-state logic of the transmit coalescing
// controller. Depends on txcc_pkg.
module txcc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  txcc_pkg::item_t               item_i,
  input  logic [txcc_pkg::WindowW-1:0]  join_window_i,
  output txcc_pkg::result_t             result_o
);
  import txcc_pkg::*;

  ctrl_state_e        state_q, state_d;
  req_status_e        status_q, status_d;
  logic               armed_q, armed_d;
  logic [WindowW-1:0] elapsed_q, elapsed_d;
  logic [1:0]         sent_q, sent_d;
  logic               done_seen_q, done_seen_d;
  logic               busy_q, busy_d;

  logic       accepted, start, clr, stby, ended;
  logic [1:0] src;

  assign src = {status_q == RS_PENDING, item_i.system_ready};

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    armed_d     = armed_q;
    elapsed_d   = elapsed_q;
    sent_d      = sent_q;
    done_seen_d = done_seen_q;
    busy_d      = busy_q;
    accepted    = 1'b0;
    start       = 1'b0;
    clr         = 1'b0;
    stby        = 1'b0;
    ended       = 1'b0;
    case (item_i.op)
      OP_REQUEST: begin
        if (item_i.request_valid && status_q != RS_PENDING) begin
          status_d = RS_PENDING;
          accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (status_q == RS_DONE || status_q == RS_FAILED) status_d = RS_IDLE;
      end
      OP_DONE: done_seen_d = 1'b1;
      OP_TICK: begin
        if (armed_q && elapsed_q != ElapsedMax) elapsed_d = elapsed_q + 1'b1;
      end
      OP_RUN: begin
        case (state_q)
          ST_INIT: state_d = item_i.radio_ok ? ST_WAIT : ST_HALT;
          ST_WAIT: begin
            if (!busy_q && !item_i.busy_pin) begin
              if (src == 2'b00) begin
                armed_d = 1'b0;
              end else if (src != SrcBoth && !armed_q) begin
                armed_d   = 1'b1;
                elapsed_d = '0;
              end else if (src == SrcBoth || elapsed_q >= join_window_i) begin
                armed_d = 1'b0;
                sent_d  = src;
                busy_d  = 1'b1;
                state_d = ST_START;
              end
            end
          end
          ST_START: begin
            done_seen_d = 1'b0;
            start       = 1'b1;
            if (item_i.radio_ok) begin
              state_d = ST_DONEWAIT;
            end else begin
              if (sent_q[SrcReqBit]) status_d = RS_FAILED;
              ended   = 1'b1;
              sent_d  = '0;
              busy_d  = 1'b0;
              state_d = ST_WAIT;
            end
          end
          ST_DONEWAIT: begin
            if (done_seen_q) begin
              done_seen_d = 1'b0;
              stby        = 1'b1;
              if (sent_q[SrcReqBit]) status_d = RS_DONE;
              clr     = sent_q[SrcSysBit];
              ended   = 1'b1;
              sent_d  = '0;
              busy_d  = 1'b0;
              state_d = ST_WAIT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.fsm_state          = state_d;
    result_o.tx_status          = status_d;
    result_o.request_accepted   = accepted;
    result_o.start_transmit     = start;
    result_o.packet_sources     = ended ? sent_q : sent_d;
    result_o.clear_system_ready = clr;
    result_o.standby            = stby;
    result_o.busy_res           = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      status_q    <= RS_IDLE;
      armed_q     <= 1'b0;
      elapsed_q   <= '0;
      sent_q      <= '0;
      done_seen_q <= 1'b0;
      busy_q      <= 1'b0;
    end else if (step_i) begin
      state_q     <= state_d;
      status_q    <= status_d;
      armed_q     <= armed_d;
      elapsed_q   <= elapsed_d;
      sent_q      <= sent_d;
      done_seen_q <= done_seen_d;
      busy_q      <= busy_d;
    end
  end

endmodule

// ===== design/tx_coalescing_controller_top.sv =====
// Top level of the transmit coalescing controller: input and result registers
// around the controller core. Depends on txcc_pkg and txcc_core.
//
// Use:
//   The slave stream carries one item per handshake: an op (run step,
//   transmit request, clear status, done interrupt, time tick) with the
//   request, system-ready, busy-pin and radio-result flags. Every item gives
//   exactly one result item on the master stream: state and request status
//   after the item, the request-accepted flag, the start/standby/clear pulses,
//   the packet sources and the busy flag.
//   cfg_we_i writes the join window (ticks) from cfg_wdata_i; write it only
//   while no item is in flight.
// Flow:
//   An accepted item is held in the input register, is processed by the core
//   and is then held in the result register, which drives the master stream.
//   One item per cycle is sustained while the receiver keeps m_axis_tready_i
//   high; the core's next-state logic is combinational.
// Reset:
//   rst_ni (asynchronous, active low) empties both registers, puts the
//   controller in init with status idle, and loads a join window of 100.
// Stall:
//   While the receiver holds m_axis_tready_i low, the result holds; one more
//   item is taken into the input register, then s_axis_tready_o drops.
module tx_coalescing_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] op, [3] request_valid, [4] system_ready, [5] busy_pin,
  // [6] radio_ok, [7] zero
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] fsm_state, [4:3] tx_status, [5] request_accepted,
  // [6] start_transmit, [8:7] packet_sources, [9] clear_system_ready,
  // [10] standby, [11] busy_res, [15:12] zero
  output logic [15:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import txcc_pkg::*;

  logic               in_valid_q;
  item_t              in_item_q;
  logic               out_valid_q;
  result_t            out_res_q;
  logic [WindowW-1:0] window_q;
  logic               out_free;
  logic               advance;
  logic               take_in;
  result_t            core_res;

  // The result register is free when empty or being drained this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // Input register: load on accept, empty when the item moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_item_q <= item_t'(s_axis_tdata_i[ItemW-1:0]);
    end
  end

  txcc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_item_q),
    .join_window_i (window_q),
    .result_o      (core_res)
  );

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - ResultW){1'b0}}, out_res_q};

  // Busy is reported exactly while a transmission is being started or run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.busy_res ==
      (out_res_q.fsm_state == ST_START || out_res_q.fsm_state == ST_DONEWAIT)))
    else $error("busy flag disagrees with controller state");

  // Standby ends a transmission: back to waiting with the radio released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.standby) |->
      (out_res_q.fsm_state == ST_WAIT && !out_res_q.busy_res))
    else $error("standby without returning to waiting");

  // Start pulse leaves the controller awaiting done or back in waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.start_transmit) |->
      (out_res_q.fsm_state == ST_DONEWAIT || out_res_q.fsm_state == ST_WAIT))
    else $error("start pulse with unexpected next state");

  // An item in the input register moves on whenever the result slot frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (!out_valid_q || m_axis_tready_i)) |=> out_valid_q)
    else $error("item not advanced into the result register");

endmodule
